// ===== design/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// Swap slot table package
// Shared widths, codes and record types of the swap slot table manager.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

  localparam int SLOTS   = 1024;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int OWNER_W = 16;
  localparam int PAGE_W  = 20;
  localparam int CFG_W   = 11;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [OWNER_W-1:0] owner_t;
  typedef logic [PAGE_W-1:0]  page_t;

  typedef enum logic [1:0] {
    REQ_ALLOC     = 2'd0,
    REQ_LOAD      = 2'd1,
    REQ_REL_OWNER = 2'd2,
    REQ_NOP       = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SLOT   = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY    = 2'd0,
    SLOT_ALLOC    = 2'd1,
    SLOT_RELEASED = 2'd2
  } slot_state_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MATCH,
    S_FREE,
    S_RELO,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    slot_state_t state;
    owner_t      owner;
    page_t       page;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic        rd_en;
    idx_t        rd_addr;
    logic        wr_en;
    idx_t        wr_addr;
    slot_entry_t wr_data;
  } mem_req_t;

  typedef struct packed {
    status_t status;
    idx_t    idx;
    logic    prev_valid;
    owner_t  prev_owner;
    page_t   prev_page;
  } result_t;

endpackage

`default_nettype wire

// ===== design/sst_ram.sv =====
// ----------------------------------------------------------------------------
// Slot table RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 38
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/sst_ctrl.sv =====
// ----------------------------------------------------------------------------
// Slot table sequencer
// Walks the slot RAM one entry per cycle and does the read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sst_pkg::req_t       req,
  input  sst_pkg::owner_t     owner,
  input  sst_pkg::page_t      page,
  input  sst_pkg::cnt_t       slot_count,
  output sst_pkg::mem_req_t   mreq,
  input  sst_pkg::slot_entry_t rd_entry,
  output logic                res_valid,
  input  logic                res_take,
  output sst_pkg::result_t    res
);

  import sst_pkg::*;

  ctrl_state_t state_r, state_nxt;
  req_t        op_r, op_nxt;
  owner_t      own_r, own_nxt;
  page_t       page_r, page_nxt;
  cnt_t        n_r, n_nxt;
  cnt_t        iss_cnt_r, iss_cnt_nxt;
  idx_t        iss_addr_r, iss_addr_nxt;
  logic        d_vld_r, d_vld_nxt;
  idx_t        d_addr_r, d_addr_nxt;
  logic        d_last_r, d_last_nxt;
  idx_t        ptr_r, ptr_nxt;
  idx_t        clr_cnt_r, clr_cnt_nxt;
  result_t     res_r, res_nxt;

  logic        tag_hit;
  logic        own_hit;
  logic        end_now;
  logic        scanning;

  // Next address in a ring of n entries.
  function automatic idx_t wrap_inc(input idx_t a, input cnt_t n);
    cnt_t sum;
    sum = CNT_W'(a) + CNT_W'(1);
    return (sum == n) ? '0 : sum[IDX_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      d_vld_r   <= 1'b0;
      ptr_r     <= '0;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      d_vld_r   <= d_vld_nxt;
      ptr_r     <= ptr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    own_r      <= own_nxt;
    page_r     <= page_nxt;
    n_r        <= n_nxt;
    iss_cnt_r  <= iss_cnt_nxt;
    iss_addr_r <= iss_addr_nxt;
    d_addr_r   <= d_addr_nxt;
    d_last_r   <= d_last_nxt;
    res_r      <= res_nxt;
  end

  assign tag_hit = (rd_entry.state != SLOT_EMPTY) && (rd_entry.owner == own_r) &&
                   (rd_entry.page == page_r);
  assign own_hit = (rd_entry.state != SLOT_EMPTY) && (rd_entry.owner == own_r);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    own_nxt      = own_r;
    page_nxt     = page_r;
    n_nxt        = n_r;
    iss_cnt_nxt  = iss_cnt_r;
    iss_addr_nxt = iss_addr_r;
    d_vld_nxt    = 1'b0;
    d_addr_nxt   = d_addr_r;
    d_last_nxt   = d_last_r;
    ptr_nxt      = ptr_r;
    clr_cnt_nxt  = clr_cnt_r;
    res_nxt      = res_r;
    mreq         = '0;
    end_now      = 1'b0;
    scanning     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mreq.wr_en         = 1'b1;
        mreq.wr_addr       = clr_cnt_r;
        mreq.wr_data.state = SLOT_EMPTY;
        clr_cnt_nxt        = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = req;
          own_nxt      = owner;
          page_nxt     = page;
          n_nxt        = slot_count;
          iss_cnt_nxt  = '0;
          iss_addr_nxt = '0;
          res_nxt      = '0;
          unique case (req)
            REQ_ALLOC: begin
              if (slot_count == '0) begin
                res_nxt.status = STAT_NO_SLOT;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_MATCH;
              end
            end
            REQ_LOAD: begin
              if (slot_count == '0) begin
                res_nxt.status = STAT_NOT_FOUND;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_MATCH;
              end
            end
            REQ_REL_OWNER: begin
              state_nxt = (slot_count == '0) ? S_DONE : S_RELO;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_MATCH: begin
        scanning = 1'b1;
        if (d_vld_r) begin
          if (tag_hit) begin
            end_now   = 1'b1;
            state_nxt = S_DONE;
            if (op_r == REQ_ALLOC) begin
              mreq.wr_en         = 1'b1;
              mreq.wr_addr       = d_addr_r;
              mreq.wr_data       = rd_entry;
              mreq.wr_data.state = SLOT_ALLOC;
              res_nxt.status     = STAT_OK;
              res_nxt.idx        = d_addr_r;
              res_nxt.prev_valid = 1'b1;
              res_nxt.prev_owner = rd_entry.owner;
              res_nxt.prev_page  = rd_entry.page;
            end else if (rd_entry.state == SLOT_ALLOC) begin
              mreq.wr_en         = 1'b1;
              mreq.wr_addr       = d_addr_r;
              mreq.wr_data       = rd_entry;
              mreq.wr_data.state = SLOT_RELEASED;
              res_nxt.status     = STAT_OK;
              res_nxt.idx        = d_addr_r;
            end else begin
              res_nxt.status = STAT_NOT_FOUND;
            end
          end else if (d_last_r) begin
            end_now = 1'b1;
            if (op_r == REQ_ALLOC) begin
              // No tag match: fall back to the round-robin free search.
              state_nxt    = S_FREE;
              iss_cnt_nxt  = '0;
              iss_addr_nxt = (CNT_W'(ptr_r) < n_r) ? ptr_r : '0;
            end else begin
              res_nxt.status = STAT_NOT_FOUND;
              state_nxt      = S_DONE;
            end
          end
        end
      end

      S_FREE: begin
        scanning = 1'b1;
        if (d_vld_r) begin
          if (rd_entry.state != SLOT_ALLOC) begin
            end_now            = 1'b1;
            state_nxt          = S_DONE;
            mreq.wr_en         = 1'b1;
            mreq.wr_addr       = d_addr_r;
            mreq.wr_data.state = SLOT_ALLOC;
            mreq.wr_data.owner = own_r;
            mreq.wr_data.page  = page_r;
            ptr_nxt            = wrap_inc(d_addr_r, n_r);
            res_nxt.status     = STAT_OK;
            res_nxt.idx        = d_addr_r;
            if (rd_entry.state != SLOT_EMPTY) begin
              res_nxt.prev_valid = 1'b1;
              res_nxt.prev_owner = rd_entry.owner;
              res_nxt.prev_page  = rd_entry.page;
            end
          end else if (d_last_r) begin
            end_now        = 1'b1;
            res_nxt.status = STAT_NO_SLOT;
            state_nxt      = S_DONE;
          end
        end
      end

      S_RELO: begin
        scanning = 1'b1;
        if (d_vld_r) begin
          if (own_hit) begin
            mreq.wr_en         = 1'b1;
            mreq.wr_addr       = d_addr_r;
            mreq.wr_data       = rd_entry;
            mreq.wr_data.state = SLOT_EMPTY;
          end
          if (d_last_r) begin
            end_now   = 1'b1;
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Read issue runs one entry ahead of the evaluation stage.
    if (scanning && (iss_cnt_r < n_r) && !end_now) begin
      mreq.rd_en   = 1'b1;
      mreq.rd_addr = iss_addr_r;
      iss_cnt_nxt  = iss_cnt_r + CNT_W'(1);
      iss_addr_nxt = wrap_inc(iss_addr_r, n_r);
      d_vld_nxt    = 1'b1;
      d_addr_nxt   = iss_addr_r;
      d_last_nxt   = ((iss_cnt_r + CNT_W'(1)) == n_r);
    end
  end

endmodule

`default_nettype wire

// ===== design/swap_slot_table_manager.sv =====
// ----------------------------------------------------------------------------
// Swap slot table manager
// Table of swap slots with tag lookup, round-robin allocation and release.
// ----------------------------------------------------------------------------
// Operation: a load or a release-owner request scans the n active slots once before
// the result is offered; an allocate scans them for the tag, then for a free slot.
// Requests with n = 0 go straight to the result.
// Throughput: one request at a time; the single RAM read port reads one slot
// per cycle, and the next request is taken in the cycle after the result moves out.
// Reset: state clears at once, then a clearing pass empties every slot.
// ----------------------------------------------------------------------------
`default_nettype none

module swap_slot_table_manager (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_req_type,
  input  sst_pkg::owner_t        in_owner_id,
  input  sst_pkg::page_t         in_page_number,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_status,
  output sst_pkg::idx_t          out_slot_index,
  output logic                   out_prev_valid,
  output sst_pkg::owner_t        out_prev_owner,
  output sst_pkg::page_t         out_prev_page,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [sst_pkg::CFG_W-1:0] cfg_data
);

  import sst_pkg::*;

  // The slot count register is always writable; software must write it only
  // while no request is in flight, and the block itself does not enforce this.
  logic [CFG_W-1:0] slot_count_r;
  cnt_t             active_n;

  mem_req_t         mreq;
  logic [ENTRY_W-1:0] ram_rd_data;
  slot_entry_t      rd_entry;

  logic             res_valid;
  logic             res_take;
  result_t          res;

  // Output register: lets the sequencer take the next request while the
  // previous result waits for the consumer.
  logic             out_valid_r;
  result_t          out_res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= '0;
    end else if (cfg_valid) begin
      slot_count_r <= cfg_data;
    end
  end

  // A count beyond the table size is clamped to the table size.
  assign active_n = (slot_count_r > CFG_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(slot_count_r);

  sst_ram #(
    .DEPTH (SLOTS),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mreq.wr_en),
    .wr_addr (mreq.wr_addr),
    .wr_data (mreq.wr_data),
    .rd_en   (mreq.rd_en),
    .rd_addr (mreq.rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_entry = slot_entry_t'(ram_rd_data);

  sst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req        (req_t'(in_req_type)),
    .owner      (in_owner_id),
    .page       (in_page_number),
    .slot_count (active_n),
    .mreq       (mreq),
    .rd_entry   (rd_entry),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  // The finished result moves into the output register whenever it is empty
  // or being drained in the same cycle.
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_slot_index = out_res_r.idx;
  assign out_prev_valid = out_res_r.prev_valid;
  assign out_prev_owner = out_res_r.prev_owner;
  assign out_prev_page  = out_res_r.prev_page;

  // After reset the clearing pass holds off new requests.
  a_clear_blocks_requests: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request port open during the clearing pass");

  // A not-found answer never carries a slot or a displaced tag.
  a_not_found_is_bare: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_NOT_FOUND) |-> (out_slot_index == '0) && !out_prev_valid)
    else $error("not-found result carries slot data");

  // A new result appears only when the sequencer offered one.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(res_valid))
    else $error("result appeared without a finished request");

  // The sequencer never accepts a request while it still holds a result.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !res_valid)
    else $error("request accepted while a result is pending");

endmodule

`default_nettype wire

// ===== test/swap_slot_table_manager_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swap slot table manager testbench
// Drives allocate, load, owner-release and unused-code requests into the
// slot table under several slot counts. Every result is checked field by
// field against a cycle-free software copy of the table kept in this bench.
// ----------------------------------------------------------------------------
module swap_slot_table_manager_tb;
  import sst_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  // The slowest request is an allocate over 1024 slots, which may scan them twice.
  // The limit also covers the clearing pass after reset and long receiver
  // stalls, with a wide margin.
  localparam int STALL_LIMIT   = 12000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int TRAFFIC_ITEMS = 185;
  localparam int BLOCK_ITEMS   = 37;
  localparam int TAGS          = 8;

  // Fixed tags for the directed part. Tag A carries the all-ones extremes and
  // tag B the all-zeros extremes.
  localparam owner_t OWN_A = 16'hFFFF;
  localparam page_t  PG_A  = 20'hFFFFF;
  localparam owner_t OWN_B = 16'h0000;
  localparam page_t  PG_B  = 20'h00000;
  localparam owner_t OWN_C = 16'h5A5A;
  localparam page_t  PG_C  = 20'hA5A5A;
  localparam owner_t OWN_D = 16'h1234;
  localparam page_t  PG_D  = 20'h0F0F0;
  localparam owner_t OWN_E = 16'hC3C3;
  localparam page_t  PG_E  = 20'h3C3C3;
  localparam owner_t OWN_G = 16'h8001;
  localparam page_t  PG_G  = 20'h80001;

  // Inputs of the block, all known from time zero.
  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic [1:0]         in_req_type    = REQ_NOP;
  owner_t             in_owner_id    = '0;
  page_t              in_page_number = '0;
  logic               out_ready      = 1'b0;
  logic               cfg_valid      = 1'b0;
  logic [CFG_W-1:0]   cfg_data       = '0;

  // Outputs of the block.
  logic               in_ready;
  logic               out_valid;
  logic [1:0]         out_status;
  idx_t               out_slot_index;
  logic               out_prev_valid;
  owner_t             out_prev_owner;
  page_t              out_prev_page;
  logic               cfg_ready;

  // Software copy of the slot table and its configuration.
  slot_state_t        tbl_state [SLOTS];
  owner_t             tbl_owner [SLOTS];
  page_t              tbl_page  [SLOTS];
  int unsigned        next_search;
  logic [CFG_W-1:0]   cfg_slot_count;

  // Results still owed by the block, oldest first.
  result_t            pending_results [$];

  int                 send_idle_pct = 20;
  int                 recv_idle_pct = 50;
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  int                 settings_seen = 0;
  int                 requests_by_code [4] = '{0, 0, 0, 0};

  swap_slot_table_manager u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_owner_id    (in_owner_id),
    .in_page_number (in_page_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_prev_valid (out_prev_valid),
    .out_prev_owner (out_prev_owner),
    .out_prev_page  (out_prev_page),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // The receiver drops ready at random; with recv_idle_pct at zero it never
  // stalls.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // First non-empty slot below n that holds the tag, or n when none does.
  function automatic int unsigned tag_lookup(input int unsigned n, input owner_t o,
                                             input page_t p);
    int unsigned i;
    for (i = 0; i < n; i = i + 1) begin
      if (tbl_state[i] != SLOT_EMPTY && tbl_owner[i] == o && tbl_page[i] == p) begin
        return i;
      end
    end
    return n;
  endfunction

  // Applies one request to the software table and returns the result that
  // the block has to give for it.
  function automatic result_t predict_result(input logic [1:0] req, input owner_t o,
                                             input page_t p);
    result_t     res;
    int unsigned n;
    int unsigned hit;
    int unsigned pos;
    int unsigned k;
    bit          found;
    res = '0;
    res.status = STAT_OK;
    found = 1'b0;
    // Counts above the table size saturate to the full table.
    n = (cfg_slot_count > SLOTS) ? SLOTS : cfg_slot_count;
    case (req)
      REQ_ALLOC: begin
        if (n == 0) begin
          res.status = STAT_NO_SLOT;
        end else begin
          hit = tag_lookup(n, o, p);
          if (hit < n) begin
            // A tag hit is reported with the tag itself as the previous tag,
            // even when the slot is already allocated.
            tbl_state[hit]  = SLOT_ALLOC;
            res.idx         = hit[IDX_W-1:0];
            res.prev_valid  = 1'b1;
            res.prev_owner  = tbl_owner[hit];
            res.prev_page   = tbl_page[hit];
          end else begin
            // Round-robin search; a pointer at or past the count restarts at 0.
            pos = (next_search < n) ? next_search : 0;
            k = 0;
            while (!found && k < n) begin
              if (tbl_state[pos] != SLOT_ALLOC) begin
                found = 1'b1;
              end else begin
                pos = (pos + 1 == n) ? 0 : pos + 1;
                k = k + 1;
              end
            end
            if (!found) begin
              res.status = STAT_NO_SLOT;
            end else begin
              next_search = (pos + 1 == n) ? 0 : pos + 1;
              if (tbl_state[pos] != SLOT_EMPTY) begin
                res.prev_valid = 1'b1;
                res.prev_owner = tbl_owner[pos];
                res.prev_page  = tbl_page[pos];
              end
              tbl_state[pos] = SLOT_ALLOC;
              tbl_owner[pos] = o;
              tbl_page[pos]  = p;
              res.idx        = pos[IDX_W-1:0];
            end
          end
        end
      end
      REQ_LOAD: begin
        hit = tag_lookup(n, o, p);
        if (hit < n && tbl_state[hit] == SLOT_ALLOC) begin
          tbl_state[hit] = SLOT_RELEASED;
          res.idx        = hit[IDX_W-1:0];
        end else begin
          res.status = STAT_NOT_FOUND;
        end
      end
      REQ_REL_OWNER: begin
        for (k = 0; k < n; k = k + 1) begin
          if (tbl_state[k] != SLOT_EMPTY && tbl_owner[k] == o) begin
            tbl_state[k] = SLOT_EMPTY;
          end
        end
      end
      default: begin
        // The unused code changes nothing and answers with all zeros.
      end
    endcase
    return res;
  endfunction

  // Sends one request, with an optional random gap before it. Returns right
  // after the edge at which the request was taken, with valid still high so
  // that back-to-back requests need no second assignment in the same step.
  task automatic send_request(input logic [1:0] req, input owner_t o, input page_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_owner_id    <= o;
    in_page_number <= p;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_result(req, o, p));
    requests_by_code[req] = requests_by_code[req] + 1;
  endtask

  // Writes the slot count once the block has delivered every owed result,
  // so the table is idle while the setting changes.
  task automatic write_slot_count(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_slot_count = value;
    settings_seen = settings_seen + 1;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    mismatches = mismatches + 1;
  endtask

  // Every result taken from the block is held against the oldest owed one.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d slot %0d", $time, out_status,
                 out_slot_index);
        mismatches = mismatches + 1;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_status));
        if (out_slot_index !== want.idx)
          report_mismatch("slot_index", 32'(want.idx), 32'(out_slot_index));
        if (out_prev_valid !== want.prev_valid)
          report_mismatch("prev_valid", 32'(want.prev_valid), 32'(out_prev_valid));
        if (out_prev_owner !== want.prev_owner)
          report_mismatch("prev_owner", 32'(want.prev_owner), 32'(out_prev_owner));
        if (out_prev_page !== want.prev_page)
          report_mismatch("prev_page", 32'(want.prev_page), 32'(out_prev_page));
      end
    end
  end

  // Watchdog: any request moving on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
      $display("[swap_slot_table_manager] ERROR");
      $finish;
    end
  end

  // With no slots, allocate must report no free slot and load must miss.
  task automatic test_no_slots();
    write_slot_count(0);
    send_request(REQ_ALLOC, OWN_A, PG_A);
    send_request(REQ_LOAD, OWN_A, PG_A);
    send_request(REQ_REL_OWNER, OWN_A, PG_A);
    send_request(REQ_NOP, OWN_A, PG_A);
  endtask

  // Two slots: fill the table, hit an allocated tag, load and miss on a
  // released slot, displace a released tag, and empty one owner's slots.
  task automatic test_small_table();
    write_slot_count(2);
    send_request(REQ_ALLOC, OWN_A, PG_A);
    send_request(REQ_ALLOC, OWN_B, PG_B);
    send_request(REQ_ALLOC, OWN_C, PG_C);     // table full
    send_request(REQ_ALLOC, OWN_A, PG_A);     // hit on an allocated slot
    send_request(REQ_LOAD, OWN_A, PG_A);
    send_request(REQ_LOAD, OWN_A, PG_A);      // slot now released, so a miss
    send_request(REQ_ALLOC, OWN_C, PG_C);     // takes over the released tag
    send_request(REQ_LOAD, OWN_B, PG_B);
    send_request(REQ_REL_OWNER, OWN_B, PG_C);
    send_request(REQ_LOAD, OWN_B, PG_B);      // emptied, so a miss
    send_request(REQ_ALLOC, OWN_A, PG_A);
  endtask

  // Moves the search pointer to slot 3 under four slots, then shrinks the
  // table to three so the next free search has to restart at slot 0.
  task automatic test_stale_pointer();
    write_slot_count(4);
    send_request(REQ_ALLOC, OWN_D, PG_D);
    send_request(REQ_LOAD, OWN_C, PG_C);
    write_slot_count(3);
    send_request(REQ_ALLOC, OWN_E, PG_E);
  endtask

  // The largest count saturates to the full table; a few requests walk all
  // of it, then the exact table size is used.
  task automatic test_saturated_count();
    write_slot_count({CFG_W{1'b1}});
    send_request(REQ_ALLOC, OWN_G, PG_G);
    send_request(REQ_LOAD, OWN_G, PG_G);
    send_request(REQ_ALLOC, OWN_G, PG_G);     // hit on a released slot
    send_request(REQ_REL_OWNER, OWN_G, PG_A);
    send_request(REQ_LOAD, OWN_A, PG_A);
    write_slot_count(CFG_W'(SLOTS));
    send_request(REQ_ALLOC, owner_t'($urandom_range(0, 16'hFFFF)),
                 page_t'($urandom_range(0, 20'hFFFFF)));
    send_request(REQ_LOAD, owner_t'($urandom_range(0, 16'hFFFF)),
                 page_t'($urandom_range(0, 20'hFFFFF)));
  endtask

  // Random traffic in blocks, each block under a fresh slot count. Most
  // requests draw from a small set of tags so that hits, loads, a full table
  // and displacement happen often; the rest are fully random fields.
  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    owner_t owners [4];
    owner_t tag_own [TAGS];
    page_t  tag_pg [TAGS];
    int     k;
    int     j;
    int     pick;
    int     cnt;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (j = 0; j < 4; j = j + 1) owners[j] = owner_t'($urandom_range(0, 16'hFFFF));
    for (k = 0; k < TRAFFIC_ITEMS; k = k + 1) begin
      if (k % BLOCK_ITEMS == 0) begin
        // Mostly small tables keep the scans short.
        pick = $urandom_range(99);
        if (pick < 8) cnt = 0;
        else if (pick < 65) cnt = $urandom_range(1, 6);
        else if (pick < 93) cnt = $urandom_range(7, 16);
        else cnt = $urandom_range(17, 48);
        write_slot_count(CFG_W'(cnt));
        for (j = 0; j < TAGS; j = j + 1) begin
          tag_own[j] = owners[$urandom_range(0, 3)];
          tag_pg[j]  = page_t'($urandom_range(0, 20'hFFFFF));
        end
      end
      pick = $urandom_range(99);
      j = $urandom_range(0, TAGS - 1);
      if (pick < 45)
        send_request(REQ_ALLOC, tag_own[j], tag_pg[j]);
      else if (pick < 80)
        send_request(REQ_LOAD, tag_own[j], tag_pg[j]);
      else if (pick < 90)
        send_request(REQ_REL_OWNER, tag_own[j], page_t'($urandom_range(0, 20'hFFFFF)));
      else
        send_request(2'($urandom_range(0, 3)), owner_t'($urandom_range(0, 16'hFFFF)),
                     page_t'($urandom_range(0, 20'hFFFFF)));
    end
  endtask

  initial begin : main_sequence
    int i;
    for (i = 0; i < SLOTS; i = i + 1) begin
      tbl_state[i] = SLOT_EMPTY;
      tbl_owner[i] = '0;
      tbl_page[i]  = '0;
    end
    next_search    = 0;
    cfg_slot_count = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part runs with the first idling setting.
    test_no_slots();
    test_small_table();
    test_stale_pointer();
    test_saturated_count();

    // Sender idles more lightly first, then the receiver, then neither.
    test_random_traffic(20, 50);
    test_random_traffic(50, 20);
    test_random_traffic(0, 0);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d allocate, %0d load, %0d owner release and %0d unused-code requests",
             requests_by_code[REQ_ALLOC], requests_by_code[REQ_LOAD],
             requests_by_code[REQ_REL_OWNER], requests_by_code[REQ_NOP]);
    $display("across %0d slot-count settings, from no slots to a saturated full table.",
             settings_seen);
    if (mismatches == 0) begin
      $display("[swap_slot_table_manager] OK");
    end else begin
      $display("[swap_slot_table_manager] ERROR");
    end
    $finish;
  end

endmodule
